// ===== src/frs_pkg.sv =====
package frs_pkg;

  // Filter and rate geometry
  localparam int TAP_COUNT   = 42;
  localparam int RATE_RATIO  = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int COEF_FRAC   = 17;

  // Sum of |tap| is below 2^COEF_SUM_BITS, which bounds the accumulator
  localparam int COEF_SUM_BITS = 18;

  localparam int ADDR_W = $clog2(TAP_COUNT);
  localparam int TAP_W  = $clog2(TAP_COUNT);
  localparam int CNT_W  = $clog2(RATE_RATIO);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = SAMPLE_BITS + COEF_SUM_BITS;

  // Output gain: 6 in interpolate, 29491/2^15 (0.9) in decimate
  localparam int GAIN_W       = 16;
  localparam int DEC_GAIN_NUM = 29491;
  localparam int DEC_SHIFT    = 32;
  localparam int MUL_W        = ACC_W + GAIN_W;

  localparam logic signed [MUL_W-1:0] RND_INT = MUL_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [MUL_W-1:0] RND_DEC = MUL_W'(1) <<< (DEC_SHIFT - 1);
  localparam logic signed [MUL_W-1:0] SAT_HI  = (MUL_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [MUL_W-1:0] SAT_LO  = -(MUL_W'(1) <<< (SAMPLE_BITS - 1));

  // Mode register codes
  localparam logic MODE_INTERP = 1'b0;
  localparam logic MODE_DECIM  = 1'b1;

  // Q0.17 low-pass taps, symmetric
  localparam logic signed [COEF_BITS-1:0] COEF [TAP_COUNT] = '{
    18'sd159,   18'sd179,   18'sd190,   18'sd169,   18'sd81,
    -18'sd109,  -18'sd416,  -18'sd821,  -18'sd1255, -18'sd1606,
    -18'sd1721, -18'sd1442, -18'sd632,  18'sd788,   18'sd2810,
    18'sd5322,  18'sd8116,  18'sd10907, 18'sd13378, 18'sd15226,
    18'sd16214, 18'sd16214, 18'sd15226, 18'sd13378, 18'sd10907,
    18'sd8116,  18'sd5322,  18'sd2810,  18'sd788,   -18'sd632,
    -18'sd1442, -18'sd1721, -18'sd1606, -18'sd1255, -18'sd821,
    -18'sd416,  -18'sd109,  18'sd81,    18'sd169,   18'sd190,
    18'sd179,   18'sd159
  };

  // Control that travels with an accumulator into the output scaler
  typedef struct packed {
    logic mode;
    logic last;
  } scale_ctl_t;

endpackage

// ===== src/frs_ram.sv =====
module frs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 42
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/frs_scale.sv =====
module frs_scale import frs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  scale_ctl_t                    ctl,
  input  logic signed [ACC_W-1:0]       acc,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          result_last
);

  logic                    s1_v;
  scale_ctl_t              s1_ctl;
  logic signed [MUL_W-1:0] s1_prod;
  logic signed [MUL_W-1:0] acc_ext;
  logic signed [MUL_W-1:0] gain_ext;
  logic signed [MUL_W-1:0] rnd;

  assign acc_ext  = MUL_W'(acc);
  assign gain_ext = (ctl.mode == MODE_DECIM) ? MUL_W'(DEC_GAIN_NUM) : MUL_W'(RATE_RATIO);

  // Stage 1: gain multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    if (start) begin
      s1_prod <= acc_ext * gain_ext;
      s1_ctl  <= ctl;
    end
  end

  // Round half up, then drop the fraction bits
  always_comb begin
    if (s1_ctl.mode == MODE_DECIM) begin
      rnd = (s1_prod + RND_DEC) >>> DEC_SHIFT;
    end else begin
      rnd = (s1_prod + RND_INT) >>> COEF_FRAC;
    end
  end

  // Stage 2: saturate to sample width
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_v;
    end
    if (s1_v) begin
      result_last <= s1_ctl.last;
      if (rnd > SAT_HI) begin
        result <= SAT_HI[SAMPLE_BITS-1:0];
      end else if (rnd < SAT_LO) begin
        result <= SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        result <= rnd[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// ===== src/fir_resampler_by_six_core.sv =====
// Each filter output is one delay-line RAM read per tap (tap 0 takes the new sample directly)
// through a single multiply-accumulate, then pipeline drain, scaling and output load.
// Interpolate: six filter outputs per input word. Decimate: one word in six yields a result,
// the others are only written to the delay line. in_stall holds off words until back in idle.
// Reset (rst, synchronous) and any mode write clear the delay line at once (valid bits).
module fir_resampler_by_six_core import frs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          last_of_run
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WRITE = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                        state;
  logic                          mode;
  logic [ADDR_W-1:0]             head;
  logic [CNT_W-1:0]              phase;
  logic [CNT_W-1:0]              push_k;
  logic signed [SAMPLE_BITS-1:0] push_smp;
  logic                          calc;
  logic [TAP_COUNT-1:0]          line_vld;
  logic [ADDR_W-1:0]             rd_addr;
  logic [TAP_W-1:0]              tap;
  logic                          rd_v;
  logic [TAP_W-1:0]              rd_tap;
  logic                          rd_ok;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_v;
  logic signed [ACC_W-1:0]       acc;

  logic                          in_take;
  logic                          out_free;
  logic                          last_push;
  logic [ADDR_W-1:0]             head_inc;
  logic [ADDR_W-1:0]             issue_addr;
  logic [ADDR_W-1:0]             issue_addr_dec;
  logic [TAP_W-1:0]              issue_tap;
  logic                          issue;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] tap_smp;
  logic                          sc_start;
  scale_ctl_t                    sc_ctl;
  logic                          sc_done;
  logic signed [SAMPLE_BITS-1:0] sc_result;
  logic                          sc_last;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_push = (mode == MODE_DECIM) || (push_k == CNT_W'(RATE_RATIO - 1));

  // Circular addressing: newest sample at head, older ones below it
  assign head_inc   = (head == ADDR_W'(TAP_COUNT - 1)) ? '0 : head + 1'b1;
  assign issue_addr = (state == ST_WRITE)
                    ? ((head_inc == '0) ? ADDR_W'(TAP_COUNT - 1) : head_inc - 1'b1)
                    : rd_addr;
  assign issue_addr_dec = (issue_addr == '0) ? ADDR_W'(TAP_COUNT - 1) : issue_addr - 1'b1;
  assign issue_tap  = (state == ST_WRITE) ? TAP_W'(1) : tap;
  assign issue      = ((state == ST_WRITE) && calc) || (state == ST_READ);

  frs_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(TAP_COUNT)
  ) u_line (
    .clk  (clk),
    .we   (state == ST_WRITE),
    .waddr(head_inc),
    .wdata(push_smp),
    .raddr(issue_addr),
    .rdata(ram_rdata)
  );

  // Entries not written since the last clear read as zero
  assign tap_smp = rd_ok ? $signed(ram_rdata) : '0;

  assign sc_start = (state == ST_DRAIN) && !rd_v && !prod_v;
  assign sc_ctl   = '{mode: mode, last: last_push};

  frs_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (sc_start),
    .ctl        (sc_ctl),
    .acc        (acc),
    .done       (sc_done),
    .result     (sc_result),
    .result_last(sc_last)
  );

  // Read, multiply, accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= issue;
      prod_v <= rd_v || ((state == ST_WRITE) && calc);
    end
    rd_tap <= issue_tap;
    rd_ok  <= line_vld[issue_addr];
    if (rd_v) begin
      prod <= tap_smp * COEF[rd_tap];
    end else begin
      prod <= push_smp * COEF[0];
    end
    if (state == ST_WRITE) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Sequencer and delay-line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_INTERP;
      head     <= '0;
      phase    <= '0;
      line_vld <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            push_smp <= in_sample;
            push_k   <= '0;
            calc     <= (mode == MODE_INTERP) || (phase == '0);
            if (mode == MODE_DECIM) begin
              phase <= (phase == CNT_W'(RATE_RATIO - 1)) ? '0 : phase + 1'b1;
            end
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          head               <= head_inc;
          line_vld[head_inc] <= 1'b1;
          rd_addr            <= issue_addr_dec;
          tap                <= issue_tap + 1'b1;
          if (!calc) begin
            state <= ST_IDLE;
          end else if (issue_tap == TAP_W'(TAP_COUNT - 1)) begin
            state <= ST_DRAIN;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          rd_addr <= issue_addr_dec;
          tap     <= tap + 1'b1;
          if (tap == TAP_W'(TAP_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sc_start) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (sc_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_push) begin
              state <= ST_IDLE;
            end else begin
              push_k   <= push_k + 1'b1;
              push_smp <= '0;
              state    <= ST_WRITE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Mode write clears the line and the phase
      if (cfg_wen) begin
        mode     <= cfg_wdata;
        head     <= '0;
        phase    <= '0;
        line_vld <= '0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if ((state == ST_EMIT) && out_free) begin
      out_sample  <= sc_result;
      last_of_run <= sc_last;
    end
  end

endmodule
